>>> sv/box_corner_overlap_test_macros.svh
// Assertion macros for the checker file of the box corner overlap test.
`ifndef BOX_CORNER_OVERLAP_TEST_MACROS_SVH
`define BOX_CORNER_OVERLAP_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BCOT_HOLDS(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BCOT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bcot_pkg.sv
`timescale 1ns / 1ps
package bcot_pkg;

  // Scratch memory geometry.
  localparam int ADDR_W    = 7;
  localparam int MEM_DEPTH = 128;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [3:0]        opc_t;

  // Request kinds.
  localparam logic [2:0] KIND_OWN_MAT = 3'd0;
  localparam logic [2:0] KIND_OTH_MAT = 3'd1;
  localparam logic [2:0] KIND_OWN_COL = 3'd2;
  localparam logic [2:0] KIND_OTH_COL = 3'd3;
  localparam logic [2:0] KIND_EVAL    = 3'd4;

  // Collider words above this index are dropped.
  localparam logic [3:0] COL_LAST = 4'd6;

  // Micro-operation codes.
  localparam opc_t OP_ADD  = 4'd0;
  localparam opc_t OP_SUB  = 4'd1;
  localparam opc_t OP_MUL  = 4'd2;
  localparam opc_t OP_DIV  = 4'd3;
  localparam opc_t OP_LT   = 4'd4;
  localparam opc_t OP_CINI = 4'd5;
  localparam opc_t OP_CFIN = 4'd6;
  localparam opc_t OP_CHK  = 4'd7;
  localparam opc_t OP_END  = 4'd8;

  typedef struct packed {
    opc_t  opc;
    addr_t a;
    addr_t b;
    addr_t dst;
    logic  za;
    logic  zb;
  } op_t;

  // Memory map of stored words and scratch values.
  localparam addr_t A_OWN_MAT = 7'd0;
  localparam addr_t A_OTH_MAT = 7'd16;
  localparam addr_t A_OWN_COL = 7'd32;
  localparam addr_t A_OWN_HS  = 7'd36;
  localparam addr_t A_OTH_COL = 7'd40;
  localparam addr_t A_OTH_HS  = 7'd44;
  localparam addr_t A_COF     = 7'd48;
  localparam addr_t A_INV     = 7'd64;
  localparam addr_t A_P       = 7'd80;
  localparam addr_t A_W       = 7'd84;
  localparam addr_t A_L       = 7'd88;
  localparam addr_t A_T0      = 7'd92;
  localparam addr_t A_T1      = 7'd93;
  localparam addr_t A_TA      = 7'd94;
  localparam addr_t A_TB      = 7'd95;
  localparam addr_t A_TC      = 7'd96;
  localparam addr_t A_DET     = 7'd97;

endpackage

>>> sv/box_corner_overlap_test.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// request   req_valid, req_stall   kind, index, value
// response  rsp_valid, rsp_stall   collide, singular
//
// A load request leaves the block ready for the next one.
// An evaluate runs a micro-sequence on one shared unit with a shift-add multiplier.
// A singular own matrix ends the evaluate after the determinant.
// Reset clears the sequencer and handshake state; stored words are undefined.
// The response holds while rsp_stall is high, and no request is taken meanwhile.
module box_corner_overlap_test import bcot_pkg::*; #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         kind,
  input  logic [3:0]         index,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               collide,
  output logic               singular
);

  localparam int W = WORD_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_RDB   = 3'd2;
  localparam logic [2:0] S_OPB   = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]          state;
  op_t                 op;
  logic                seq_start;
  logic                seq_adv;
  logic signed [W-1:0] val_w;
  logic signed [W-1:0] opa;
  logic [W-1:0]        rdata;
  logic                we;
  addr_t               waddr;
  logic [W-1:0]        wdata;
  addr_t               raddr;
  logic                alu_start;
  logic signed [W-1:0] alu_b;
  logic                alu_done;
  logic signed [W-1:0] alu_res;
  logic                alu_lt;
  logic                accept;
  logic                load_we;
  addr_t               load_addr;
  logic                in_box;
  logic                hit;
  logic                det_zero;
  logic                wb;

  // Fit the incoming word into the working word width.
  generate
    if (WORD_BITS >= 32) begin : g_ext
      assign val_w = W'(value);
    end else begin : g_clamp
      localparam logic signed [31:0] VMAX = (32'sd1 <<< (WORD_BITS - 1)) - 32'sd1;
      localparam logic signed [31:0] VMIN = -(32'sd1 <<< (WORD_BITS - 1));
      assign val_w = (value > VMAX) ? W'(VMAX) : ((value < VMIN) ? W'(VMIN) : W'(value));
    end
  endgenerate

  assign req_stall = (state != S_IDLE);
  assign rsp_valid = (state == S_OUT);
  assign accept    = req_valid && !req_stall;

  // Load requests write one stored word; collider words above COL_LAST are dropped.
  always_comb begin
    load_we   = 1'b0;
    load_addr = A_OWN_MAT;
    case (kind)
      KIND_OWN_MAT: begin load_we = 1'b1; load_addr = A_OWN_MAT + addr_t'(index); end
      KIND_OTH_MAT: begin load_we = 1'b1; load_addr = A_OTH_MAT + addr_t'(index); end
      KIND_OWN_COL: begin
        load_we   = (index <= COL_LAST);
        load_addr = A_OWN_COL + addr_t'(index);
      end
      KIND_OTH_COL: begin
        load_we   = (index <= COL_LAST);
        load_addr = A_OTH_COL + addr_t'(index);
      end
      default: load_we = 1'b0;
    endcase
  end

  assign wb        = (state == S_EXEC) && alu_done && (op.opc != OP_LT);
  assign we        = (accept && load_we) || wb;
  assign waddr     = (state == S_IDLE) ? load_addr : op.dst;
  assign wdata     = (state == S_IDLE) ? val_w : alu_res;
  assign raddr     = (state == S_RDB) ? op.b : op.a;
  assign alu_start = (state == S_OPB);
  assign alu_b     = op.zb ? '0 : $signed(rdata);
  assign seq_start = accept && (kind == KIND_EVAL);
  assign seq_adv   = ((state == S_FETCH) && (op.opc == OP_CINI || op.opc == OP_CFIN ||
                      (op.opc == OP_CHK && !det_zero))) ||
                     ((state == S_EXEC) && alu_done);

  bcot_ram #(
    .WIDTH(W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  bcot_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .start(seq_start),
    .adv  (seq_adv),
    .op   (op)
  );

  bcot_alu #(
    .WORD_BITS    (WORD_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .opc   (op.opc),
    .a     (opa),
    .b     (alu_b),
    .done  (alu_done),
    .result(alu_res),
    .lt    (alu_lt)
  );

  // Operation control: fetch, read two operands, run the shared unit, write back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (seq_start) begin
            hit   <= 1'b0;
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          case (op.opc)
            OP_CINI: in_box <= 1'b1;
            OP_CFIN: hit <= hit | in_box;
            OP_CHK: begin
              if (det_zero) begin
                collide  <= 1'b0;
                singular <= 1'b1;
                state    <= S_OUT;
              end
            end
            OP_END: begin
              collide  <= hit;
              singular <= 1'b0;
              state    <= S_OUT;
            end
            default: state <= S_RDB;
          endcase
        end
        S_RDB: begin
          opa   <= op.za ? '0 : $signed(rdata);
          state <= S_OPB;
        end
        S_OPB: state <= S_EXEC;
        S_EXEC: begin
          if (alu_done) begin
            if (op.opc == OP_LT) begin
              in_box <= in_box & alu_lt;
            end
            if (op.dst == A_DET) begin
              det_zero <= (alu_res == '0);
            end
            state <= S_FETCH;
          end
        end
        S_OUT: begin
          if (!rsp_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bcot_ram.sv
`timescale 1ns / 1ps
module bcot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bcot_seq.sv
`timescale 1ns / 1ps
module bcot_seq import bcot_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic adv,
  output op_t  op
);

  localparam logic [3:0] PH_MINOR = 4'd0;
  localparam logic [3:0] PH_DETI  = 4'd1;
  localparam logic [3:0] PH_DET   = 4'd2;
  localparam logic [3:0] PH_CHK   = 4'd3;
  localparam logic [3:0] PH_INV   = 4'd4;
  localparam logic [3:0] PH_CINI  = 4'd5;
  localparam logic [3:0] PH_PNT   = 4'd6;
  localparam logic [3:0] PH_MVW   = 4'd7;
  localparam logic [3:0] PH_MVL   = 4'd8;
  localparam logic [3:0] PH_TST   = 4'd9;
  localparam logic [3:0] PH_CFIN  = 4'd10;
  localparam logic [3:0] PH_DONE  = 4'd11;

  logic [3:0] phase;
  logic [3:0] q;
  logic [3:0] s;
  logic [2:0] k;
  logic [3:0] q_max;
  logic [3:0] s_max;
  logic [1:0] qr;
  logic [1:0] qc;
  logic [1:0] vc;
  logic       minus;

  function automatic op_t mk(opc_t opc, addr_t a, addr_t b, addr_t dst, logic za, logic zb);
    op_t o;
    o.opc = opc;
    o.a   = a;
    o.b   = b;
    o.dst = dst;
    o.za  = za;
    o.zb  = zb;
    return o;
  endfunction

  function automatic addr_t at(addr_t base, logic [3:0] off);
    return base + addr_t'(off);
  endfunction

  // Row or column n of a 3x3 minor, skipping the deleted one.
  function automatic logic [1:0] skp(logic [1:0] del, logic [1:0] n);
    return (n < del) ? n : n + 2'd1;
  endfunction

  // Element (i,j) of the minor of the own matrix at (rr,cc).
  function automatic addr_t el(logic [1:0] rr, logic [1:0] cc, logic [1:0] i, logic [1:0] j);
    return at(A_OWN_MAT, {skp(rr, i), skp(cc, j)});
  endfunction

  assign qr    = q[3:2];
  assign qc    = q[1:0];
  assign vc    = s[2:1];
  assign minus = (qc == 2'd0) ? k[2] : ((qc == 2'd1) ? k[1] : k[0]);

  // Loop bounds of each phase.
  always_comb begin
    case (phase)
      PH_MINOR: begin q_max = 4'd15; s_max = 4'd14; end
      PH_DET:   begin q_max = 4'd3;  s_max = 4'd1;  end
      PH_INV:   begin q_max = 4'd15; s_max = 4'd0;  end
      PH_PNT:   begin q_max = 4'd2;  s_max = 4'd1;  end
      PH_MVW:   begin q_max = 4'd3;  s_max = 4'd8;  end
      PH_MVL:   begin q_max = 4'd3;  s_max = 4'd8;  end
      PH_TST:   begin q_max = 4'd2;  s_max = 4'd3;  end
      default:  begin q_max = 4'd0;  s_max = 4'd0;  end
    endcase
  end

  // Step, loop and phase counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_DONE;
      q     <= '0;
      s     <= '0;
      k     <= '0;
    end else if (start) begin
      phase <= PH_MINOR;
      q     <= '0;
      s     <= '0;
      k     <= '0;
    end else if (adv) begin
      if (s != s_max) begin
        s <= s + 4'd1;
      end else begin
        s <= '0;
        if (q != q_max) begin
          q <= q + 4'd1;
        end else begin
          q <= '0;
          if (phase == PH_CFIN) begin
            if (k == 3'd7) begin
              phase <= PH_DONE;
            end else begin
              k     <= k + 3'd1;
              phase <= PH_CINI;
            end
          end else if (phase != PH_DONE) begin
            phase <= phase + 4'd1;
          end
        end
      end
    end
  end

  // Micro-operation for the current step.
  always_comb begin
    op = mk(OP_END, A_T0, A_T0, A_T0, 1'b0, 1'b0);
    case (phase)
      PH_MINOR: begin
        case (s)
          4'd0:  op = mk(OP_MUL, el(qr, qc, 2'd1, 2'd1), el(qr, qc, 2'd2, 2'd2), A_T0, 1'b0, 1'b0);
          4'd1:  op = mk(OP_MUL, el(qr, qc, 2'd1, 2'd2), el(qr, qc, 2'd2, 2'd1), A_T1, 1'b0, 1'b0);
          4'd2:  op = mk(OP_SUB, A_T0, A_T1, A_TA, 1'b0, 1'b0);
          4'd3:  op = mk(OP_MUL, el(qr, qc, 2'd1, 2'd0), el(qr, qc, 2'd2, 2'd2), A_T0, 1'b0, 1'b0);
          4'd4:  op = mk(OP_MUL, el(qr, qc, 2'd1, 2'd2), el(qr, qc, 2'd2, 2'd0), A_T1, 1'b0, 1'b0);
          4'd5:  op = mk(OP_SUB, A_T0, A_T1, A_TB, 1'b0, 1'b0);
          4'd6:  op = mk(OP_MUL, el(qr, qc, 2'd1, 2'd0), el(qr, qc, 2'd2, 2'd1), A_T0, 1'b0, 1'b0);
          4'd7:  op = mk(OP_MUL, el(qr, qc, 2'd1, 2'd1), el(qr, qc, 2'd2, 2'd0), A_T1, 1'b0, 1'b0);
          4'd8:  op = mk(OP_SUB, A_T0, A_T1, A_TC, 1'b0, 1'b0);
          4'd9:  op = mk(OP_MUL, el(qr, qc, 2'd0, 2'd0), A_TA, A_T0, 1'b0, 1'b0);
          4'd10: op = mk(OP_MUL, el(qr, qc, 2'd0, 2'd1), A_TB, A_T1, 1'b0, 1'b0);
          4'd11: op = mk(OP_SUB, A_T0, A_T1, A_T0, 1'b0, 1'b0);
          4'd12: op = mk(OP_MUL, el(qr, qc, 2'd0, 2'd2), A_TC, A_T1, 1'b0, 1'b0);
          4'd13: op = mk(OP_ADD, A_T0, A_T1, A_T0, 1'b0, 1'b0);
          default: begin
            // Odd positions negate the minor to form the cofactor.
            if (qr[0] ^ qc[0]) begin
              op = mk(OP_SUB, A_T0, A_T0, at(A_COF, q), 1'b1, 1'b0);
            end else begin
              op = mk(OP_ADD, A_T0, A_T0, at(A_COF, q), 1'b0, 1'b1);
            end
          end
        endcase
      end
      PH_DETI: op = mk(OP_ADD, A_DET, A_DET, A_DET, 1'b1, 1'b1);
      PH_DET: begin
        if (s == 4'd0) begin
          op = mk(OP_MUL, at(A_OWN_MAT, q), at(A_COF, q), A_T0, 1'b0, 1'b0);
        end else begin
          op = mk(OP_ADD, A_DET, A_T0, A_DET, 1'b0, 1'b0);
        end
      end
      PH_CHK:  op = mk(OP_CHK, A_DET, A_DET, A_DET, 1'b0, 1'b0);
      PH_INV:  op = mk(OP_DIV, at(A_COF, {q[1:0], q[3:2]}), A_DET, at(A_INV, q), 1'b0, 1'b0);
      PH_CINI: op = mk(OP_CINI, A_T0, A_T0, A_T0, 1'b0, 1'b0);
      PH_PNT: begin
        if (s == 4'd0) begin
          if (minus) begin
            op = mk(OP_SUB, A_T0, at(A_OTH_HS, q), A_T0, 1'b1, 1'b0);
          end else begin
            op = mk(OP_ADD, at(A_OTH_HS, q), A_T0, A_T0, 1'b0, 1'b1);
          end
        end else begin
          op = mk(OP_ADD, at(A_OTH_COL, q), A_T0, at(A_P, q), 1'b0, 1'b0);
        end
      end
      PH_MVW, PH_MVL: begin
        if (s == 4'd0) begin
          op = mk(OP_ADD, A_T0, A_T0, (phase == PH_MVW) ? at(A_W, q) : at(A_L, q), 1'b1, 1'b1);
        end else if (s[0]) begin
          if (phase == PH_MVW) begin
            op = mk(OP_MUL, at(A_OTH_MAT, {qc, vc}),
                    (vc == 2'd3) ? at(A_OTH_COL, 4'd3) : at(A_P, {2'b00, vc}),
                    A_T0, 1'b0, 1'b0);
          end else begin
            op = mk(OP_MUL, at(A_INV, {qc, vc}), at(A_W, {2'b00, vc}), A_T0, 1'b0, 1'b0);
          end
        end else begin
          if (phase == PH_MVW) begin
            op = mk(OP_ADD, at(A_W, q), A_T0, at(A_W, q), 1'b0, 1'b0);
          end else begin
            op = mk(OP_ADD, at(A_L, q), A_T0, at(A_L, q), 1'b0, 1'b0);
          end
        end
      end
      PH_TST: begin
        case (s)
          4'd0:    op = mk(OP_SUB, at(A_L, q), at(A_OWN_COL, q), A_T0, 1'b0, 1'b0);
          4'd1:    op = mk(OP_SUB, A_T1, at(A_OWN_HS, q), A_T1, 1'b1, 1'b0);
          4'd2:    op = mk(OP_LT, A_T1, A_T0, A_T1, 1'b0, 1'b0);
          default: op = mk(OP_LT, A_T0, at(A_OWN_HS, q), A_T0, 1'b0, 1'b0);
        endcase
      end
      PH_CFIN: op = mk(OP_CFIN, A_T0, A_T0, A_T0, 1'b0, 1'b0);
      default: op = mk(OP_END, A_T0, A_T0, A_T0, 1'b0, 1'b0);
    endcase
  end

endmodule

>>> sv/bcot_alu.sv
`timescale 1ns / 1ps
module bcot_alu import bcot_pkg::*; #(
  parameter int WORD_BITS     = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  opc_t                        opc,
  input  logic signed [WORD_BITS-1:0] a,
  input  logic signed [WORD_BITS-1:0] b,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] result,
  output logic                        lt
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int NW = W + F;
  localparam int CW = $clog2(NW + 1);
  localparam logic [W-1:0]   WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W:0]   HALF = {{(2*W){1'b0}}, 1'b1} << (F - 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_MFIN = 3'd2;
  localparam logic [2:0] A_DIV  = 3'd3;
  localparam logic [2:0] A_DFIN = 3'd4;

  logic [2:0]    st;
  logic [CW-1:0] cnt;
  logic [W-1:0]  mc;
  logic [W-1:0]  hi;
  logic [W-1:0]  lo;
  logic [NW-1:0] nq;
  logic [W-1:0]  rem;
  logic          neg;

  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W:0]    as_sum;
  logic [W-1:0]  as_res;
  logic [W:0]    mstep;
  logic [2*W:0]  mround;
  logic [2*W:0]  mmag;
  logic [W-1:0]  mres;
  logic [W:0]    rr;
  logic          ge;
  logic [W:0]    rsub;
  logic          rup;
  logic [NW:0]   dq;
  logic [W-1:0]  dres;

  assign mag_a = a[W-1] ? (~a + 1'b1) : a;
  assign mag_b = b[W-1] ? (~b + 1'b1) : b;

  // Saturating add and subtract.
  assign as_sum = (opc == OP_SUB) ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
  assign as_res = (as_sum[W] != as_sum[W-1]) ? (as_sum[W] ? WMIN : WMAX) : as_sum[W-1:0];

  // Shift-add multiply step, then round half away and saturate.
  assign mstep  = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(W+1){1'b0}});
  assign mround = {1'b0, hi, lo} + HALF;
  assign mmag   = mround >> F;
  assign mres   = (mmag > (2*W+1)'(WMAX)) ? (neg ? WMIN : WMAX)
                : (neg ? (~mmag[W-1:0] + 1'b1) : mmag[W-1:0]);

  // Restoring divide step, then round half away and saturate.
  assign rr   = {rem, nq[NW-1]};
  assign ge   = rr >= {1'b0, mc};
  assign rsub = rr - {1'b0, mc};
  assign rup  = {rem, 1'b0} >= {1'b0, mc};
  assign dq   = {1'b0, nq} + (NW+1)'(rup);
  assign dres = (dq > (NW+1)'(WMAX)) ? (neg ? WMIN : WMAX)
              : (neg ? (~dq[W-1:0] + 1'b1) : dq[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= A_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        A_IDLE: begin
          if (start) begin
            neg <= a[W-1] ^ b[W-1];
            case (opc)
              OP_MUL: begin
                mc  <= mag_b;
                lo  <= mag_a;
                hi  <= '0;
                cnt <= CW'(W);
                st  <= A_MUL;
              end
              OP_DIV: begin
                mc  <= mag_b;
                nq  <= {mag_a, {F{1'b0}}};
                rem <= '0;
                cnt <= CW'(NW);
                st  <= A_DIV;
              end
              OP_LT: begin
                lt   <= a < b;
                done <= 1'b1;
              end
              default: begin
                result <= as_res;
                done   <= 1'b1;
              end
            endcase
          end
        end
        A_MUL: begin
          hi  <= mstep[W:1];
          lo  <= {mstep[0], lo[W-1:1]};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            st <= A_MFIN;
          end
        end
        A_MFIN: begin
          result <= mres;
          done   <= 1'b1;
          st     <= A_IDLE;
        end
        A_DIV: begin
          rem <= ge ? rsub[W-1:0] : rr[W-1:0];
          nq  <= {nq[NW-2:0], ge};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            st <= A_DFIN;
          end
        end
        A_DFIN: begin
          result <= dres;
          done   <= 1'b1;
          st     <= A_IDLE;
        end
        default: st <= A_IDLE;
      endcase
    end
  end

endmodule

>>> sv/bcot_checker.sv
`timescale 1ns / 1ps
`include "box_corner_overlap_test_macros.svh"
module bcot_checker import bcot_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic [2:0]         kind,
  input logic [3:0]         index,
  input logic signed [31:0] value,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic               collide,
  input logic               singular
);

  // A stalled response keeps its fields.
  `BCOT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(collide) && $stable(singular), "stalled response changed")

  // A singular matrix never reports a collision.
  `BCOT_HOLDS(a_rsp_excl, clk, rst, rsp_valid, !(collide && singular), "collide with singular")

  // No request is taken while a response is pending.
  `BCOT_HOLDS(a_busy_out, clk, rst, rsp_valid, req_stall, "request taken during response")

  // An evaluate makes the block busy without an immediate response.
  `BCOT_NEXT(a_eval_busy, clk, rst, req_valid && !req_stall && kind == KIND_EVAL, req_stall && !rsp_valid, "evaluate not started")

  // Loads and unknown kinds leave the block ready.
  `BCOT_NEXT(a_load_ready, clk, rst, req_valid && !req_stall && kind != KIND_EVAL, !req_stall && (index == index) && (value == value), "load stalled the block")

endmodule

bind box_corner_overlap_test bcot_checker u_bcot_checker (.*);
